[rtl/tpsw_pkg.sv]
package tpsw_pkg;

   localparam int LINE_CAPACITY_DEFAULT = 64;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int REG_ADDR_W = 4;
   localparam int SEG_W      = 8;
   localparam int VALUE_W    = 10;
   localparam int DIGIT_W    = 4;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;

   localparam logic [SEG_W-1:0] SEG_LABEL_C = 8'h4E;
   localparam logic [SEG_W-1:0] SEG_LABEL_T = 8'h0F;
   localparam logic [SEG_W-1:0] SEG_DP      = 8'h80;

   typedef struct packed {
      logic               good;
      logic [VALUE_W-1:0] first_value;
      logic               first_negative;
      logic [VALUE_W-1:0] second_value;
      logic               second_negative;
   } line_status_type;

   function automatic logic [SEG_W-1:0] seg_digit(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0: p = 8'h7E;
         4'd1: p = 8'h30;
         4'd2: p = 8'h6D;
         4'd3: p = 8'h79;
         4'd4: p = 8'h33;
         4'd5: p = 8'h5B;
         4'd6: p = 8'h5F;
         4'd7: p = 8'h70;
         4'd8: p = 8'h7F;
         4'd9: p = 8'h7B;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

[rtl/tpsw_parser.sv]
module tpsw_parser
   import tpsw_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [REQ_DATA_W-1:0] rx_byte,
   output line_status_type       status
);

   localparam int CW = $clog2(LINE_CAPACITY);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_CAPACITY - 1);

   typedef enum logic [2:0] {
      PH_SKIP1,
      PH_NEG1,
      PH_DIG1,
      PH_SKIP2,
      PH_NEG2,
      PH_DIG2,
      PH_DONE,
      PH_FAIL
   } phase_type;

   logic [CW-1:0]      count_ff, count_in;
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] first_value_ff, first_value_in;
   logic               first_negative_ff, first_negative_in;
   logic [VALUE_W-1:0] second_value_ff, second_value_in;
   logic               second_negative_ff, second_negative_in;
   logic               text_ended_ff, text_ended_in;

   logic is_space;
   logic is_digit;

   function automatic logic [VALUE_W-1:0] sat_acc(input logic [VALUE_W-1:0] v,
                                                   input logic [DIGIT_W-1:0] d);
      logic [13:0] n;
      n = 14'({4'b0, v} * 14'd10) + {10'b0, d};
      return (n > {4'b0, VALUE_MAX}) ? VALUE_MAX : n[VALUE_W-1:0];
   endfunction

   assign is_space = (rx_byte inside {[8'h09:8'h0D], 8'h20});
   assign is_digit = (rx_byte inside {[8'h30:8'h39]});

   always_comb begin
      count_in           = count_ff;
      phase_in           = phase_ff;
      first_value_in     = first_value_ff;
      first_negative_in  = first_negative_ff;
      second_value_in    = second_value_ff;
      second_negative_in = second_negative_ff;
      text_ended_in      = text_ended_ff;
      if (accept) begin
         if (rx_byte == CHAR_LF) begin
            count_in           = '0;
            phase_in           = PH_SKIP1;
            first_value_in     = '0;
            first_negative_in  = 1'b0;
            second_value_in    = '0;
            second_negative_in = 1'b0;
            text_ended_in      = 1'b0;
         end else if (rx_byte != CHAR_CR && count_ff != COUNT_LIMIT) begin
            count_in = count_ff + 1'b1;
            if (!text_ended_ff) begin
               if (rx_byte == CHAR_NUL) begin
                  text_ended_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_SKIP1: begin
                        if (rx_byte == CHAR_MINUS) begin
                           first_negative_in = 1'b1;
                           phase_in          = PH_NEG1;
                        end else if (is_digit) begin
                           first_value_in = sat_acc('0, rx_byte[3:0]);
                           phase_in       = PH_DIG1;
                        end else if (!is_space) begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_NEG1: begin
                        if (is_digit) begin
                           first_value_in = sat_acc('0, rx_byte[3:0]);
                           phase_in       = PH_DIG1;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_DIG1: begin
                        if (is_digit) begin
                           first_value_in = sat_acc(first_value_ff, rx_byte[3:0]);
                        end else if (rx_byte == CHAR_COMMA) begin
                           phase_in = PH_SKIP2;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_SKIP2: begin
                        if (rx_byte == CHAR_MINUS) begin
                           second_negative_in = 1'b1;
                           phase_in           = PH_NEG2;
                        end else if (is_digit) begin
                           second_value_in = sat_acc('0, rx_byte[3:0]);
                           phase_in        = PH_DIG2;
                        end else if (!is_space) begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_NEG2: begin
                        if (is_digit) begin
                           second_value_in = sat_acc('0, rx_byte[3:0]);
                           phase_in        = PH_DIG2;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_DIG2: begin
                        if (is_digit) begin
                           second_value_in = sat_acc(second_value_ff, rx_byte[3:0]);
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff           <= '0;
         phase_ff           <= PH_SKIP1;
         first_value_ff     <= '0;
         first_negative_ff  <= 1'b0;
         second_value_ff    <= '0;
         second_negative_ff <= 1'b0;
         text_ended_ff      <= 1'b0;
      end else begin
         count_ff           <= count_in;
         phase_ff           <= phase_in;
         first_value_ff     <= first_value_in;
         first_negative_ff  <= first_negative_in;
         second_value_ff    <= second_value_in;
         second_negative_ff <= second_negative_in;
         text_ended_ff      <= text_ended_in;
      end
   end

   assign status.good            = (phase_ff == PH_DIG2) || (phase_ff == PH_DONE);
   assign status.first_value     = first_value_ff;
   assign status.first_negative  = first_negative_ff;
   assign status.second_value    = second_value_ff;
   assign status.second_negative = second_negative_ff;

`ifndef NO_ASSERTIONS
   a_value_clamped: assert property (@(posedge clock) disable iff (reset)
      first_value_ff <= VALUE_MAX && second_value_ff <= VALUE_MAX)
      else $error("accumulator above clamp");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("stored count past line capacity");
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      accept && rx_byte == CHAR_LF |=> count_ff == '0 && !text_ended_ff)
      else $error("line state not cleared after LF");
`endif

endmodule

[rtl/tpsw_emitter.sv]
module tpsw_emitter
   import tpsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  capture,
   input  line_status_type       status,
   output logic                  busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                  burst_ff, burst_in;
   logic [2:0]            beat_ff, beat_in;
   logic [DIGIT_W-1:0]    digits_ff [6];
   logic [DIGIT_W-1:0]    digits_in [6];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [REG_ADDR_W-1:0] rsp_reg_ff, rsp_reg_in;
   logic [SEG_W-1:0]      rsp_seg_ff, rsp_seg_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  load;
   logic [VALUE_W-1:0]    v1, v2;
   logic [3*DIGIT_W-1:0]  d1, d2;
   logic [DIGIT_W-1:0]    sel_tens, sel_ones, sel_tenths;

   function automatic logic [3*DIGIT_W-1:0] split_digits(input logic [VALUE_W-1:0] v);
      logic [15:0]        p41;
      logic [17:0]        p205;
      logic [DIGIT_W-1:0] hund;
      logic [6:0]         whole;
      logic [6:0]         ones;
      logic [VALUE_W-1:0] tenths;
      p41    = {6'b0, v} * 16'd41;
      p205   = {8'b0, v} * 18'd205;
      hund   = p41[15:12];
      whole  = p205[17:11];
      ones   = whole - 7'({3'b0, hund} * 7'd10);
      tenths = v - 10'({3'b0, whole} * 10'd10);
      return {hund, ones[DIGIT_W-1:0], tenths[DIGIT_W-1:0]};
   endfunction

   assign v1 = status.first_negative ? '0 :
               (status.first_value > VALUE_MAX ? VALUE_MAX : status.first_value);
   assign v2 = status.second_negative ? '0 :
               (status.second_value > VALUE_MAX ? VALUE_MAX : status.second_value);
   assign d1 = split_digits(v1);
   assign d2 = split_digits(v2);

   assign load = burst_ff && (!rsp_valid_ff || rsp_tready);

   assign sel_tens   = beat_ff[2] ? digits_ff[3] : digits_ff[0];
   assign sel_ones   = beat_ff[2] ? digits_ff[4] : digits_ff[1];
   assign sel_tenths = beat_ff[2] ? digits_ff[5] : digits_ff[2];

   always_comb begin
      burst_in     = burst_ff;
      beat_in      = beat_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_reg_in   = rsp_reg_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;
      if (capture) begin
         burst_in     = 1'b1;
         beat_in      = '0;
         digits_in[0] = d1[11:8];
         digits_in[1] = d1[7:4];
         digits_in[2] = d1[3:0];
         digits_in[3] = d2[11:8];
         digits_in[4] = d2[7:4];
         digits_in[5] = d2[3:0];
      end else if (load) begin
         rsp_valid_in = 1'b1;
         rsp_reg_in   = {1'b0, beat_ff} + 4'd1;
         rsp_last_in  = (beat_ff == 3'd7);
         case (beat_ff[1:0])
            2'd0:    rsp_seg_in = beat_ff[2] ? SEG_LABEL_T : SEG_LABEL_C;
            2'd1:    rsp_seg_in = seg_digit(sel_tens);
            2'd2:    rsp_seg_in = seg_digit(sel_ones) | SEG_DP;
            default: rsp_seg_in = seg_digit(sel_tenths);
         endcase
         beat_in = beat_ff + 3'd1;
         if (beat_ff == 3'd7) begin
            burst_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff     <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         burst_ff     <= burst_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff   <= digits_in;
      rsp_reg_ff  <= rsp_reg_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy       = burst_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - REG_ADDR_W - SEG_W){1'b0}}, rsp_seg_ff, rsp_reg_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      capture |-> !burst_ff)
      else $error("line captured during a burst");
   a_capture_starts: assert property (@(posedge clock) disable iff (reset)
      capture |=> burst_ff && beat_ff == 3'd0)
      else $error("burst did not start after capture");
   a_last_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_reg_ff == 4'd8)
      else $error("last write not at register eight");
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      burst_ff |-> digits_ff[0] <= 4'd9 && digits_ff[1] <= 4'd9 && digits_ff[2] <= 4'd9
                   && digits_ff[3] <= 4'd9 && digits_ff[4] <= 4'd9 && digits_ff[5] <= 4'd9)
      else $error("digit out of decimal range");
`endif

endmodule

[rtl/text_pair_to_segment_writes_core.sv]
// Text line parser driving eight display digit-register writes.
// req_ channel: one received text byte per beat. CR is dropped, LF closes the
//   line, a zero byte ends the text of the line. Lines of the form
//   "<first>,<second>" with optional leading whitespace and minus signs parse
//   as good; values clamp to 0..999 and show as tens, ones.point, tenths.
// rsp_ channel: on LF after a good line, eight beats follow, digit registers
//   1..8 in order, rsp_tlast on the eighth. A bad line produces nothing.
// Throughput: one req_ beat per cycle. An LF beat waits while the previous
//   burst is still being loaded into the output register; other bytes are
//   taken every cycle even during a burst.
// Order: an accepted LF beat of a good line loads the digit registers and starts
//   the burst, which then loads the first write into the output register; with
//   rsp_tready held high the eight writes follow back to back.
// Stall: a single output register holds the current write while rsp_tready is
//   low; the burst advances one write per taken beat.
// Reset (synchronous, active high) clears the line state and drops any burst.
module text_pair_to_segment_writes_core
   import tpsw_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] digit_register, [11:4] segment_pattern
   output logic                  rsp_tlast
);

   logic            req_accept;
   logic            capture;
   logic            busy;
   line_status_type status;

   assign req_tready = !busy || (req_tdata != CHAR_LF);
   assign req_accept = req_tvalid && req_tready;
   assign capture    = req_accept && (req_tdata == CHAR_LF) && status.good;

   tpsw_parser #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_tdata),
      .status  (status)
   );

   tpsw_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .capture    (capture),
      .status     (status),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
